>>> design/u8d_pkg.sv
// u8d_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; used by u8d_decode, u8d_fifo and utf8_stream_decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int UNIT_W   = 21;
    localparam int ACC_W    = 31;
    localparam int NEED_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int TDATA_W  = 24;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [UNIT_W-1:0] REPL_RESET = 21'h00FFFD;

    localparam logic [ACC_W-1:0] SURR_LO  = 31'h0000D800;
    localparam logic [ACC_W-1:0] SURR_HI  = 31'h0000DFFF;
    localparam logic [ACC_W-1:0] CP_LIMIT = 31'h00110000;

    // register index (paddr[2])
    typedef enum logic {
        REG_REPLACEMENT = 1'b0,
        REG_WIDE_OUTPUT = 1'b1
    } reg_idx_t;

    // results of one byte: optional code unit, then optional terminator
    typedef struct packed {
        logic              unit_valid;
        logic [UNIT_W-1:0] unit;
        logic              term_valid;
    } result_t;

endpackage

`default_nettype wire

>>> design/u8d_decode.sv
// u8d_decode: sequence state (bytes needed, accumulator) and per-byte decode.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        fire,
    input  wire logic [u8d_pkg::BYTE_W-1:0]  in_byte,
    input  wire logic                        in_last,
    input  wire logic [u8d_pkg::UNIT_W-1:0]  subst_unit,
    input  wire logic                        wide,
    output u8d_pkg::result_t                 res
);

    logic [u8d_pkg::NEED_W-1:0] need_reg, need_next;
    logic [u8d_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [u8d_pkg::ACC_W-1:0]  acc_shift;
    logic [u8d_pkg::UNIT_W-1:0] raw_val;
    logic                       bad_val;

    assign acc_shift = {acc_reg[u8d_pkg::ACC_W-7:0], in_byte[5:0]};
    assign bad_val   = ((acc_shift >= u8d_pkg::SURR_LO) && (acc_shift <= u8d_pkg::SURR_HI))
                       || (acc_shift >= u8d_pkg::CP_LIMIT);

    always_comb begin
        need_next      = need_reg;
        acc_next       = acc_reg;
        raw_val        = '0;
        res.unit_valid = 1'b0;
        res.term_valid = in_last;

        if (need_reg != '0) begin
            // non-continuation bytes inside a sequence are dropped
            if (in_byte[7:6] == 2'b10) begin
                acc_next  = acc_shift;
                need_next = need_reg - 1'b1;
                if (need_reg == u8d_pkg::NEED_W'(1)) begin
                    res.unit_valid = 1'b1;
                    raw_val = bad_val ? subst_unit : acc_shift[u8d_pkg::UNIT_W-1:0];
                end
            end
        end else if (in_byte[7] == 1'b0) begin
            acc_next       = u8d_pkg::ACC_W'(in_byte);
            res.unit_valid = 1'b1;
            raw_val        = u8d_pkg::UNIT_W'(in_byte);
        end else if (in_byte[7:5] == 3'b110) begin
            acc_next  = u8d_pkg::ACC_W'(in_byte[4:0]);
            need_next = u8d_pkg::NEED_W'(1);
        end else if (in_byte[7:4] == 4'b1110) begin
            acc_next  = u8d_pkg::ACC_W'(in_byte[3:0]);
            need_next = u8d_pkg::NEED_W'(2);
        end else if (in_byte[7:3] == 5'b11110) begin
            acc_next  = u8d_pkg::ACC_W'(in_byte[2:0]);
            need_next = u8d_pkg::NEED_W'(3);
        end else if (wide && (in_byte[7:2] == 6'b111110)) begin
            acc_next  = u8d_pkg::ACC_W'(in_byte[1:0]);
            need_next = u8d_pkg::NEED_W'(4);
        end else if (wide && (in_byte[7:1] == 7'b1111110)) begin
            acc_next  = u8d_pkg::ACC_W'(in_byte[0]);
            need_next = u8d_pkg::NEED_W'(5);
        end else begin
            res.unit_valid = 1'b1;
            raw_val        = subst_unit;
        end

        if (in_last) begin
            need_next = '0;
            acc_next  = '0;
        end

        // narrow mode keeps the low 16 bits
        res.unit = wide ? raw_val : {5'd0, raw_val[15:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_reg <= '0;
            acc_reg  <= '0;
        end else if (fire) begin
            need_reg <= need_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

>>> design/u8d_fifo.sv
// u8d_fifo: small result queue, up to two pushes and one pop per cycle.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_fifo (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire u8d_pkg::result_t            res,
    output logic                             room,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [u8d_pkg::TDATA_W-1:0]      m_tdata,   // [20:0] code_unit, [23:21] zero
    output logic                             m_tlast    // terminator
);

    logic [u8d_pkg::UNIT_W-1:0] unit_reg [u8d_pkg::FIFO_DEPTH];
    logic                       term_reg [u8d_pkg::FIFO_DEPTH];

    logic [u8d_pkg::PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next, wr_plus1;
    logic [u8d_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic                       pop;
    logic [1:0]                 n_push;
    logic [u8d_pkg::UNIT_W-1:0] s0_unit;
    logic                       s0_term;

    assign pop      = m_tvalid && m_tready;
    assign room     = cnt_reg <= u8d_pkg::CNT_W'(u8d_pkg::FIFO_DEPTH - 2);
    assign wr_plus1 = wr_reg + 1'b1;

    always_comb begin
        n_push  = '0;
        s0_unit = res.unit;
        s0_term = 1'b0;
        if (push) begin
            n_push = 2'(res.unit_valid) + 2'(res.term_valid);
            if (!res.unit_valid) begin
                s0_unit = '0;
                s0_term = 1'b1;
            end
        end
        wr_next  = wr_reg + u8d_pkg::PTR_W'(n_push);
        rd_next  = rd_reg + u8d_pkg::PTR_W'(pop);
        cnt_next = cnt_reg + u8d_pkg::CNT_W'(n_push) - u8d_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload: first slot, then terminator in the second when both are present
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            unit_reg[wr_reg] <= s0_unit;
            term_reg[wr_reg] <= s0_term;
        end
        if (n_push == 2'd2) begin
            unit_reg[wr_plus1] <= '0;
            term_reg[wr_plus1] <= 1'b1;
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = u8d_pkg::TDATA_W'(unit_reg[rd_reg]);
    assign m_tlast  = term_reg[rd_reg];

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// utf8_stream_decoder: top level - APB registers, input register, decode, result queue.
// Depends on u8d_pkg, u8d_decode and u8d_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   s_ stream: one UTF-8 byte per transfer in s_tdata[7:0]; s_tlast marks the
//   final byte of a string.
//   m_ stream: one code unit per transfer in m_tdata[20:0]. m_tlast is set on
//   the closing zero unit that follows the last byte of each string.
//   APB: register 0 (addr 0x0) replacement character, 21 bits, reset 0xFFFD;
//   register 1 (addr 0x4) wide_output, 1 bit, reset 1. Write only while idle.
// Timing
//   A byte is taken into the input register, decoded combinationally from
//   it and written to a four-entry result queue whose head drives the m_
//   port; m_tvalid is derived from the registered queue count.
//   Sustained rate is one byte per cycle while the queue has room; a last
//   byte yields up to two results and the single m_ port then drains one
//   per cycle while m_tready is high, which is what limits rate.
// Stall and reset
//   When m_tready is low the queue fills; once fewer than two free entries
//   remain, decode holds and s_tready drops. Nothing is lost or repeated.
//   Reset empties the queue and input register, clears the sequence state
//   and restores both registers to their reset values.
module utf8_stream_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [u8d_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  wire logic                          s_tlast,   // last_byte
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [u8d_pkg::TDATA_W-1:0]        m_tdata,   // [20:0] code_unit, [23:21] zero
    output logic                               m_tlast,   // terminator
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u8d_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [u8d_pkg::CFG_W-1:0]     pwdata,
    output logic [u8d_pkg::CFG_W-1:0]          prdata,
    output logic                               pready
);

    // configuration registers
    logic [u8d_pkg::UNIT_W-1:0] repl_reg;
    logic                       wide_reg;
    logic                       cfg_wr;
    u8d_pkg::reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = u8d_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= u8d_pkg::REPL_RESET;
            wide_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                u8d_pkg::REG_REPLACEMENT: begin
                    repl_reg <= pwdata[u8d_pkg::UNIT_W-1:0];
                end
                u8d_pkg::REG_WIDE_OUTPUT: begin
                    wide_reg <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            u8d_pkg::REG_REPLACEMENT: prdata = u8d_pkg::CFG_W'(repl_reg);
            u8d_pkg::REG_WIDE_OUTPUT: prdata = u8d_pkg::CFG_W'(wide_reg);
            default:                  prdata = '0;
        endcase
    end

    // input register: refills in the same cycle it is consumed
    logic                       in_valid_reg;
    logic [u8d_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_last_reg;
    logic                       room;
    logic                       fire;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    u8d_pkg::result_t res;

    u8d_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .subst_unit (repl_reg),
        .wide       (wide_reg),
        .res        (res)
    );

    u8d_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fire),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
